FILE: rtl/pose_frame_transform_2d_defines.svh
// assertion helpers for the pose frame transform
`ifndef POSE_FRAME_TRANSFORM_2D_DEFINES_SVH
`define POSE_FRAME_TRANSFORM_2D_DEFINES_SVH

// implication checked on every edge outside reset
`define PFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/pft_pkg.sv
package pft_pkg;

    localparam int CordicStagesDef = 24;
    localparam int PosW = 32;
    localparam int AngW = 31;
    // internal datapath width for positions (angles use ZW)
    localparam int DatW = 40;
    localparam int ZW = 36;

    localparam logic [ZW-1:0] HalfPiQ30 = ZW'(64'd1686629713);
    localparam logic signed [31:0] GainQ30 = 32'sd652032874;
    localparam logic signed [AngW+1:0] PiQ28 = 33'sd843314857;
    localparam logic signed [AngW+1:0] TwoPiQ28 = 33'sd1686629713;

    localparam logic [1:0] RegOriginX = 2'd0;
    localparam logic [1:0] RegOriginY = 2'd1;
    localparam logic [1:0] RegOriginHeading = 2'd2;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic [31:0] t [0:31];
        t = '{32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
              32'd67021686, 32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282,
              32'd2097149, 32'd1048575, 32'd524287, 32'd262143, 32'd131071,
              32'd65535, 32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
              32'd1023, 32'd511, 32'd255, 32'd127, 32'd63, 32'd31, 32'd15, 32'd8,
              32'd4, 32'd2, 32'd1, 32'd0};
        return $signed({4'd0, t[i & 31]});
    endfunction

endpackage

FILE: rtl/pft_rotator.sv
// pipelined cordic rotation: quarter-turn fold, gain multiply, then one stage per step
module pft_rotator
    import pft_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDef,
    parameter int SW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SW-1:0]          i_side,
    input  logic signed [DatW-1:0] i_x,
    input  logic signed [DatW-1:0] i_y,
    input  logic signed [ZW-1:0]   i_z,
    output logic                   o_valid,
    output logic [SW-1:0]          o_side,
    output logic signed [DatW-1:0] o_x,
    output logic signed [DatW-1:0] o_y
);

    localparam int PW = DatW + 32;

    // fold stage
    logic                   r_fv;
    logic [SW-1:0]          r_fs;
    logic signed [DatW-1:0] r_fx, r_fy;
    logic signed [ZW-1:0]   r_fz;
    logic signed [DatW-1:0] n_fx, n_fy;
    logic signed [ZW-1:0]   n_fz;

    always_comb begin
        n_fx = i_x;
        n_fy = i_y;
        n_fz = i_z;
        for (int k = 0; k < 2; k++) begin
            if (n_fz > $signed(HalfPiQ30)) begin
                {n_fx, n_fy} = {-n_fy, n_fx};
                n_fz = n_fz - $signed(HalfPiQ30);
            end else if (n_fz < -$signed(HalfPiQ30)) begin
                {n_fx, n_fy} = {n_fy, -n_fx};
                n_fz = n_fz + $signed(HalfPiQ30);
            end
        end
    end

    // gain multiply stage
    logic                   r_mv;
    logic [SW-1:0]          r_ms;
    logic signed [PW-1:0]   r_mx, r_my;
    logic signed [ZW-1:0]   r_mz;

    logic                   r_v [0:CORDIC_STAGES];
    logic [SW-1:0]          r_s [0:CORDIC_STAGES];
    logic signed [DatW-1:0] r_x [0:CORDIC_STAGES];
    logic signed [DatW-1:0] r_y [0:CORDIC_STAGES];
    logic signed [ZW-1:0]   r_z [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_mv <= 1'b0;
            r_v[0] <= 1'b0;
        end else begin
            r_fv <= i_valid;
            r_mv <= r_fv;
            r_v[0] <= r_mv;
        end
        r_fs <= i_side;
        r_fx <= n_fx;
        r_fy <= n_fy;
        r_fz <= n_fz;
        r_ms <= r_fs;
        r_mx <= PW'(r_fx) * PW'(GainQ30) + PW'(64'sd536870912);
        r_my <= PW'(r_fy) * PW'(GainQ30) + PW'(64'sd536870912);
        r_mz <= r_fz;
        r_s[0] <= r_ms;
        r_x[0] <= DatW'(r_mx >>> 30);
        r_y[0] <= DatW'(r_my >>> 30);
        r_z[0] <= r_mz;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        logic signed [DatW-1:0] dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_s[g+1] <= r_s[g];
            if (!r_z[g][ZW-1]) begin
                r_x[g+1] <= r_x[g] - dx;
                r_y[g+1] <= r_y[g] + dy;
                r_z[g+1] <= r_z[g] - atan_q30(g);
            end else begin
                r_x[g+1] <= r_x[g] + dx;
                r_y[g+1] <= r_y[g] - dy;
                r_z[g+1] <= r_z[g] + atan_q30(g);
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES];
    assign o_side  = r_s[CORDIC_STAGES];
    assign o_x     = r_x[CORDIC_STAGES];
    assign o_y     = r_y[CORDIC_STAGES];

endmodule

FILE: rtl/pose_frame_transform_2d.sv
// pipeline from the accepting edge to o_done: a setup stage, two cordic pipelines of
// CORDIC_STAGES + 3 stages each, a translate stage, an output register.
// throughput: one request per cycle; busy stays low, every stage is a register
// so the receiver cannot stall and nothing is held back.
// reset: synchronous active-low i_rst_n clears valid bits and origin registers to 0.
module pose_frame_transform_2d
    import pft_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [PosW-1:0]        i_cfg_data,
    input  logic                   i_direction,
    input  logic signed [PosW-1:0] i_other_x,
    input  logic signed [PosW-1:0] i_other_y,
    input  logic signed [AngW-1:0] i_other_heading,
    input  logic signed [PosW-1:0] i_rel_x,
    input  logic signed [PosW-1:0] i_rel_y,
    input  logic signed [AngW-1:0] i_rel_heading,
    output logic                   o_done,
    output logic signed [PosW-1:0] o_out_x,
    output logic signed [PosW-1:0] o_out_y,
    output logic signed [AngW-1:0] o_out_heading,
    output logic                   o_overflow
);

    `include "pose_frame_transform_2d_defines.svh"

    localparam int SW1 = 2 * DatW + ZW + AngW + 2;

    logic signed [PosW-1:0] r_org_x, r_org_y;
    logic signed [AngW-1:0] r_org_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegOriginX:       r_org_x <= i_cfg_data;
                RegOriginY:       r_org_y <= i_cfg_data;
                RegOriginHeading: r_org_h <= i_cfg_data[AngW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // setup: pick source and target, work out net offset and heading
    logic signed [PosW-1:0] sx, sy, tx, ty;
    logic signed [AngW-1:0] sh, th;
    always_comb begin
        if (!i_direction) begin
            {sx, sy, sh} = {i_other_x, i_other_y, i_other_heading};
            {tx, ty, th} = {r_org_x, r_org_y, r_org_h};
        end else begin
            {sx, sy, sh} = {r_org_x, r_org_y, r_org_h};
            {tx, ty, th} = {i_other_x, i_other_y, i_other_heading};
        end
    end

    logic                   r_v0;
    logic signed [PosW-1:0] r_rx, r_ry;
    logic signed [ZW-1:0]   r_z1, r_z2;
    logic signed [DatW-1:0] r_ox, r_oy;
    logic signed [AngW+1:0] r_h0;
    logic signed [AngW+1:0] n_h;

    always_comb begin
        n_h = (AngW+2)'(i_rel_heading) - ((AngW+2)'(th) - (AngW+2)'(sh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= start;
        r_rx <= i_rel_x;
        r_ry <= i_rel_y;
        r_z1 <= ZW'(sh) <<< 2;
        r_z2 <= -(ZW'(th) <<< 2);
        r_ox <= DatW'(sx) - DatW'(tx);
        r_oy <= DatW'(sy) - DatW'(ty);
        r_h0 <= n_h;
    end

    logic                   v1;
    logic [SW1-1:0]         s1;
    logic signed [DatW-1:0] x1, y1;

    pft_rotator #(.CORDIC_STAGES(CORDIC_STAGES), .SW(SW1)) u_rot_src (
        .i_clk, .i_rst_n,
        .i_valid(r_v0), .i_side({r_ox, r_oy, r_z2, r_h0}),
        .i_x(DatW'(r_rx)), .i_y(DatW'(r_ry)), .i_z(r_z1),
        .o_valid(v1), .o_side(s1), .o_x(x1), .o_y(y1)
    );

    // translate between rotations
    logic                   r_v2;
    logic signed [DatW-1:0] r_x2, r_y2;
    logic signed [ZW-1:0]   r_z3;
    logic signed [AngW-1:0] r_h2;
    logic signed [AngW+1:0] h_raw, n_hw;

    // a single wrap step: a value pulled down from above pi stays above -pi, but one above 3*pi stays above pi
    always_comb begin
        h_raw = $signed(s1[AngW+1:0]);
        if (h_raw > PiQ28)       n_hw = h_raw - TwoPiQ28;
        else if (h_raw < -PiQ28) n_hw = h_raw + TwoPiQ28;
        else                     n_hw = h_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= v1;
        r_x2 <= x1 + s1[SW1-1 -: DatW];
        r_y2 <= y1 + s1[SW1-DatW-1 -: DatW];
        r_z3 <= s1[AngW+2+ZW-1 -: ZW];
        r_h2 <= n_hw[AngW-1:0];
    end

    logic                   v3;
    logic [AngW-1:0]        h3;
    logic signed [DatW-1:0] x3, y3;

    pft_rotator #(.CORDIC_STAGES(CORDIC_STAGES), .SW(AngW)) u_rot_dst (
        .i_clk, .i_rst_n,
        .i_valid(r_v2), .i_side(r_h2),
        .i_x(r_x2), .i_y(r_y2), .i_z(r_z3),
        .o_valid(v3), .o_side(h3), .o_x(x3), .o_y(y3)
    );

    // saturate and register the result
    localparam logic signed [DatW-1:0] MaxP = DatW'(64'sd2147483647);
    localparam logic signed [DatW-1:0] MinP = -DatW'(64'sd2147483648);
    logic ox_hi, ox_lo, oy_hi, oy_lo;
    assign ox_hi = x3 > MaxP;
    assign ox_lo = x3 < MinP;
    assign oy_hi = y3 > MaxP;
    assign oy_lo = y3 < MinP;

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= v3;
        o_out_x <= ox_hi ? MaxP[PosW-1:0] : (ox_lo ? MinP[PosW-1:0] : x3[PosW-1:0]);
        o_out_y <= oy_hi ? MaxP[PosW-1:0] : (oy_lo ? MinP[PosW-1:0] : y3[PosW-1:0]);
        o_out_heading <= h3;
        o_overflow <= ox_hi | ox_lo | oy_hi | oy_lo;
    end
    assign o_done = r_done;

    `PFT_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `PFT_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, v3, o_done)
    `PFT_ASSERT_NEXT(a_mid_follows, i_clk, i_rst_n, v1, r_v2)

endmodule
